[design/lwh_pkg.sv]
package lwh_pkg;

    // Bin store geometry
    localparam int NUM_BINS = 4096;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    // Field widths
    localparam int KIND_W      = 2;
    localparam int LABEL_W     = 20;
    localparam int LABEL_FRAC  = 8;
    localparam int ROUND_W     = LABEL_W + 1 - LABEL_FRAC;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 48;
    localparam int BIN_LABEL_W = 12;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((LABEL_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BIN_LABEL_W + SUM_W + 7) / 8) * 8;

    // One half in Q12.8
    localparam logic [LABEL_W:0] HALF_LSB = (LABEL_W + 1)'(1 << (LABEL_FRAC - 1));

    // Saturation limits of a bin sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    // Item kinds carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ACC   = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Control states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_ACC,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[design/lwh_ram.sv]
module lwh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/label_weighted_histogram.sv]
// Weighted label histogram.
// Slave stream: tuser carries the kind (accumulate, fetch, clear); tdata carries
// the Q12.8 label and the signed Q15.16 count. Master stream: one item per fetch,
// tdata holds the bin label and its 48-bit saturated sum, tuser holds found and
// the sticky label overflow flag.
// Bins live in one 4096 x 48 synchronous RAM with a registered read.
// Accumulate: read, then saturating add and write back through the single
// RAM; no new item is taken until the write-back is done. Out-of-range labels
// only set the overflow flag.
// Fetch: scans the RAM one bin per cycle from the scan position until a nonzero
// bin or the last bin, up to NUM_BINS bins; the result waits in ST_DONE for the
// output register. Once the scan has finished a fetch returns not found.
// Clear: writes zero to one bin per cycle over all NUM_BINS bins, and rewinds the scan.
// Reset starts the same clearing pass (with s_axis_tready low) and
// zeroes the scan position and the overflow flag.
// A stalled receiver holds the output register; accumulate and clear items
// still go through, and a later fetch waits only when its result is ready.
module label_weighted_histogram (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [19:0] label_value, [51:20] count_value, [55:52] zero
    input  logic [lwh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [lwh_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] bin_label, [59:12] bin_sum, [63:60] zero
    output logic [lwh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] found, [1] label_overflow_seen
    output logic [1:0]                      m_axis_tuser
);

    localparam int AW  = lwh_pkg::BIN_AW;
    localparam int SW  = lwh_pkg::SUM_W;
    localparam int CW  = lwh_pkg::COUNT_W;
    localparam int LW  = lwh_pkg::LABEL_W;
    localparam int BLW = lwh_pkg::BIN_LABEL_W;
    localparam logic [AW-1:0] LAST_BIN = AW'(lwh_pkg::NUM_BINS - 1);
    localparam logic [AW:0]   SCAN_END = (AW + 1)'(lwh_pkg::NUM_BINS);

    lwh_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW:0]     r_scan, n_scan;
    logic            r_ovf, n_ovf;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_count, n_count;
    logic            r_found, n_found;
    logic [BLW-1:0]  r_label, n_label;
    logic [SW-1:0]   r_sum, n_sum;
    logic            r_out_valid, n_out_valid;
    logic            r_out_found, n_out_found;
    logic            r_out_ovf, n_out_ovf;
    logic [BLW-1:0]  r_out_label, n_out_label;
    logic [SW-1:0]   r_out_sum, n_out_sum;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [SW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [SW-1:0]   ram_rdata;

    lwh_pkg::t_kind  in_kind;
    logic [LW-1:0]   in_label;
    logic [CW-1:0]   in_count;
    logic [LW:0]     round_sum;
    logic [lwh_pkg::ROUND_W-1:0] round_idx;
    logic            in_range;
    logic [AW:0]     scan_next;
    logic [SW:0]     acc_sum;
    logic [SW-1:0]   sat_sum;

    // Unpack the slave item
    assign in_kind  = lwh_pkg::t_kind'(s_axis_tuser);
    assign in_label = s_axis_tdata[LW-1:0];
    assign in_count = s_axis_tdata[LW+CW-1:LW];

    // Round the label to the nearest bin
    assign round_sum = {1'b0, in_label} + lwh_pkg::HALF_LSB;
    assign round_idx = round_sum[LW:lwh_pkg::LABEL_FRAC];
    assign in_range  = 32'(round_idx) < 32'(lwh_pkg::NUM_BINS);

    assign scan_next = r_scan + (AW + 1)'(1);

    // Saturating add of the count into the bin read back
    always_comb begin
        acc_sum = {ram_rdata[SW-1], ram_rdata}
                + {{(SW + 1 - CW){r_count[CW-1]}}, r_count};
        if (acc_sum[SW] != acc_sum[SW-1]) begin
            sat_sum = acc_sum[SW] ? lwh_pkg::SUM_MIN : lwh_pkg::SUM_MAX;
        end else begin
            sat_sum = acc_sum[SW-1:0];
        end
    end

    lwh_ram #(
        .WIDTH (SW),
        .DEPTH (lwh_pkg::NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state, RAM access and handshake
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_scan      = r_scan;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_count     = r_count;
        n_found     = r_found;
        n_label     = r_label;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        n_out_label = r_out_label;
        n_out_sum   = r_out_sum;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = sat_sum;
        ram_raddr   = r_scan[AW-1:0];
        s_axis_tready = 1'b0;

        // Drop the output item once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lwh_pkg::ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_BIN) begin
                    n_state = lwh_pkg::ST_IDLE;
                end
            end
            lwh_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (in_kind)
                        lwh_pkg::KIND_ACC: begin
                            if (in_range) begin
                                ram_raddr = AW'(round_idx);
                                n_addr    = AW'(round_idx);
                                n_count   = in_count;
                                n_state   = lwh_pkg::ST_ACC;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        lwh_pkg::KIND_FETCH: begin
                            if (r_scan == SCAN_END) begin
                                n_found = 1'b0;
                                n_label = '0;
                                n_sum   = '0;
                                n_state = lwh_pkg::ST_DONE;
                            end else begin
                                ram_raddr = r_scan[AW-1:0];
                                n_state   = lwh_pkg::ST_SCAN;
                            end
                        end
                        lwh_pkg::KIND_CLEAR: begin
                            n_clr   = '0;
                            n_scan  = '0;
                            n_state = lwh_pkg::ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lwh_pkg::ST_ACC: begin
                ram_we  = 1'b1;
                n_state = lwh_pkg::ST_IDLE;
            end
            lwh_pkg::ST_SCAN: begin
                // Check the bin at r_scan, prefetch the next one
                ram_raddr = scan_next[AW-1:0];
                n_scan    = scan_next;
                if (ram_rdata != '0) begin
                    n_found = 1'b1;
                    n_label = BLW'(r_scan[AW-1:0]);
                    n_sum   = ram_rdata;
                    n_state = lwh_pkg::ST_DONE;
                end else if (r_scan[AW-1:0] == LAST_BIN) begin
                    n_found = 1'b0;
                    n_label = '0;
                    n_sum   = '0;
                    n_state = lwh_pkg::ST_DONE;
                end
            end
            lwh_pkg::ST_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_ovf   = r_ovf;
                    n_out_label = r_label;
                    n_out_sum   = r_sum;
                    n_state     = lwh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lwh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lwh_pkg::ST_CLR;
            r_clr       <= '0;
            r_scan      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_scan      <= n_scan;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_count     <= n_count;
        r_found     <= n_found;
        r_label     <= n_label;
        r_sum       <= n_sum;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_label <= n_out_label;
        r_out_sum   <= n_out_sum;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(lwh_pkg::OUT_DATA_W - BLW - SW)'(0), r_out_sum, r_out_label};
    assign m_axis_tuser  = {r_out_ovf, r_out_found};

    // The overflow flag only clears at reset
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("label overflow flag dropped");

    // A found result never carries an empty bin
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_sum != '0))
        else $error("found result with zero sum");

    // Scanning never writes the bin store
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lwh_pkg::ST_SCAN) |-> !ram_we)
        else $error("write during scan");

    // Every write-back follows an accepted item
    a_acc_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lwh_pkg::ST_ACC) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("write-back without accepted item");

    // Scan position never goes past NUM_BINS, one beyond the last bin
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_END)
        else $error("scan position out of range");

endmodule

[sim/label_weighted_histogram_test.sv]
module label_weighted_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind value that the block ignores
    localparam logic [lwh_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS  = 1200;
    localparam int     SAT_ADDS      = 16;
    localparam int     IDLE_LIMIT    = 40000;
    localparam int     DRAIN_CYCLES  = lwh_pkg::NUM_BINS + 100;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     MAX_PRINTS    = 50;
    localparam longint SUM_HI        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO        = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [lwh_pkg::KIND_W-1:0]  kind;
        logic [lwh_pkg::LABEL_W-1:0] label;
        logic [lwh_pkg::COUNT_W-1:0] count;
    } t_voxel_item;

    typedef struct packed {
        logic                            found;
        logic [lwh_pkg::BIN_LABEL_W-1:0] label;
        logic [lwh_pkg::SUM_W-1:0]       sum;
        logic                            ovf;
    } t_bin_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE
    } t_rx_mode;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [19:0] label_value, [51:20] count_value, [55:52] zero
    logic [lwh_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [1:0] kind
    logic [lwh_pkg::KIND_W-1:0]     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [11:0] bin_label, [59:12] bin_sum, [63:60] zero
    logic [lwh_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // [0] found, [1] label_overflow_seen
    logic [1:0]                     m_axis_tuser;

    // Histogram shadow
    longint      bin_totals [lwh_pkg::NUM_BINS];
    int unsigned scan_ptr   = 0;
    bit          ovf_sticky = 1'b0;

    t_voxel_item pending_items [$];
    t_bin_result expected_bins [$];

    int       err_count    = 0;
    int       results_seen = 0;
    int       live_items   = 0;
    int       idle_cycles  = 0;
    bit       in_fire      = 1'b0;
    int       gap_left     = 0;
    int       burst_left   = 1;
    int       hold_left    = 0;
    int       next_hold_at = 40;
    int       mode_left    = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    label_weighted_histogram i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the shadow histogram by one accepted item
    task automatic predict_bins(input t_voxel_item it);
        logic [lwh_pkg::LABEL_W:0] rounded;
        int unsigned               idx;
        longint                    total;
        t_bin_result               res;
        case (it.kind)
            lwh_pkg::KIND_ACC: begin
                rounded = {1'b0, it.label} + lwh_pkg::HALF_LSB;
                idx     = int'(rounded >> lwh_pkg::LABEL_FRAC);
                if (idx >= lwh_pkg::NUM_BINS) begin
                    ovf_sticky = 1'b1;
                end else begin
                    total = bin_totals[idx] + longint'($signed(it.count));
                    if (total > SUM_HI) total = SUM_HI;
                    if (total < SUM_LO) total = SUM_LO;
                    bin_totals[idx] = total;
                end
            end
            lwh_pkg::KIND_CLEAR: begin
                foreach (bin_totals[i]) bin_totals[i] = 0;
                scan_ptr = 0;
            end
            lwh_pkg::KIND_FETCH: begin
                res     = '0;
                res.ovf = ovf_sticky;
                while (scan_ptr < lwh_pkg::NUM_BINS && bin_totals[scan_ptr] == 0)
                    scan_ptr++;
                if (scan_ptr < lwh_pkg::NUM_BINS) begin
                    total     = bin_totals[scan_ptr];
                    res.found = 1'b1;
                    res.label = lwh_pkg::BIN_LABEL_W'(scan_ptr);
                    res.sum   = total[lwh_pkg::SUM_W-1:0];
                    scan_ptr++;
                end
                expected_bins.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    task automatic push_item(input logic [lwh_pkg::KIND_W-1:0] kind,
                             input logic [lwh_pkg::LABEL_W-1:0] label,
                             input logic [lwh_pkg::COUNT_W-1:0] count);
        t_voxel_item it;
        it.kind  = kind;
        it.label = label;
        it.count = count;
        pending_items.push_back(it);
        if (kind != KIND_UNUSED) live_items++;
    endtask

    // Label that rounds to the given bin, with a random fraction
    function automatic logic [lwh_pkg::LABEL_W-1:0] label_for_bin(input int unsigned bin);
        int unsigned half;
        half = int'(lwh_pkg::HALF_LSB);
        if (bin == 0) return lwh_pkg::LABEL_W'($urandom_range(0, half - 1));
        return lwh_pkg::LABEL_W'((bin << lwh_pkg::LABEL_FRAC) - half
                                 + $urandom_range(0, 2 * half - 1));
    endfunction

    // Count with weight on extremes and small values
    function automatic logic [lwh_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4, 5, 6: return lwh_pkg::COUNT_W'($urandom_range(0, 2000) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus, reset and end of run
    initial begin
        int unsigned span;
        int unsigned base;
        int          n;
        int          roll;
        int          random_start;

        // Directed: rounding edges, extremes, scan behavior, ignored kind
        push_item(lwh_pkg::KIND_ACC,   20'h00000, 32'h0000_0001);
        push_item(lwh_pkg::KIND_ACC,   20'h0007F, 32'h7FFF_FFFF);
        push_item(lwh_pkg::KIND_ACC,   20'h00080, 32'h8000_0000);
        push_item(lwh_pkg::KIND_ACC,   20'h00300, 32'h0000_0003);
        push_item(lwh_pkg::KIND_ACC,   20'h002FF, 32'hFFFF_FFFD);
        push_item(lwh_pkg::KIND_ACC,   20'hFFF7F, 32'h0000_0005);
        push_item(KIND_UNUSED,         20'hFFFFF, 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_ACC,   20'hFFF80, 32'h0000_0007);
        push_item(lwh_pkg::KIND_FETCH, 20'hFFFFF, 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_ACC,   20'h00000, 32'h0000_0009);
        push_item(lwh_pkg::KIND_ACC,   20'h00A80, 32'h0000_000B);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_ACC,   20'hFFFFF, 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_CLEAR, 20'hFFFFF, 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_ACC,   20'h001FF, 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_ACC,   20'h000A0, 32'h0000_0000);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_FETCH, 20'h00000, 32'h0000_0000);
        push_item(lwh_pkg::KIND_CLEAR, 20'h00000, 32'h0000_0000);

        // Drive one bin far up and one far down, then step back, and step again after a clear
        repeat (SAT_ADDS) begin
            push_item(lwh_pkg::KIND_ACC, label_for_bin(20), 32'h7FFF_FFFF);
            push_item(lwh_pkg::KIND_ACC, label_for_bin(21), 32'h8000_0000);
        end
        push_item(lwh_pkg::KIND_FETCH, '0, '0);
        push_item(lwh_pkg::KIND_ACC, label_for_bin(20), 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_ACC, label_for_bin(21), 32'h0000_0001);
        push_item(lwh_pkg::KIND_FETCH, '0, '0);
        push_item(lwh_pkg::KIND_CLEAR, '0, '0);
        push_item(lwh_pkg::KIND_ACC, label_for_bin(20), 32'hFFFF_FFFF);
        push_item(lwh_pkg::KIND_ACC, label_for_bin(21), 32'h0000_0001);
        push_item(lwh_pkg::KIND_FETCH, '0, '0);
        push_item(lwh_pkg::KIND_FETCH, '0, '0);
        push_item(lwh_pkg::KIND_FETCH, '0, '0);

        // Random: mostly fill-then-scan runs, some raw noise
        random_start = live_items;
        while (live_items < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(4, 16))
                    push_item(lwh_pkg::KIND_W'($urandom_range(0, 3)),
                              lwh_pkg::LABEL_W'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 2) != 0)
                    push_item(lwh_pkg::KIND_CLEAR, lwh_pkg::LABEL_W'($urandom), $urandom);
                case ($urandom_range(0, 3))
                    0:       span = 2;
                    1:       span = 8;
                    2:       span = 64;
                    default: span = lwh_pkg::NUM_BINS;
                endcase
                base = $urandom_range(0, lwh_pkg::NUM_BINS - span);
                n    = $urandom_range(3, 40);
                repeat (n) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        push_item(lwh_pkg::KIND_FETCH, lwh_pkg::LABEL_W'($urandom),
                                  $urandom);
                    else if (roll < 11)
                        push_item(KIND_UNUSED, lwh_pkg::LABEL_W'($urandom), $urandom);
                    else if (roll < 14)
                        push_item(lwh_pkg::KIND_ACC,
                                  lwh_pkg::LABEL_W'($urandom_range(32'hFFF80, 32'hFFFFF)),
                                  pick_count());
                    else
                        push_item(lwh_pkg::KIND_ACC,
                                  label_for_bin(base + $urandom_range(0, span - 1)),
                                  pick_count());
                end
                repeat ($urandom_range(n / 2, n + 3)) begin
                    if ($urandom_range(0, 7) == 0)
                        push_item(lwh_pkg::KIND_ACC,
                                  label_for_bin(base + $urandom_range(0, span - 1)),
                                  pick_count());
                    else
                        push_item(lwh_pkg::KIND_FETCH, lwh_pkg::LABEL_W'($urandom),
                                  $urandom);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the stimulus, then for the results, then let the block settle
        while (pending_items.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_bins.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Predict on every accepted input item
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            predict_bins({s_axis_tuser, s_axis_tdata[lwh_pkg::LABEL_W-1:0],
                          s_axis_tdata[lwh_pkg::LABEL_W +: lwh_pkg::COUNT_W]});
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_bin_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_axis_tdata), '0);
            end else begin
                want = expected_bins.pop_front();
                if (m_axis_tuser[0] !== want.found)
                    report_mismatch("found", 64'(m_axis_tuser[0]), 64'(want.found));
                if (m_axis_tdata[lwh_pkg::BIN_LABEL_W-1:0] !== want.label)
                    report_mismatch("bin_label",
                                    64'(m_axis_tdata[lwh_pkg::BIN_LABEL_W-1:0]),
                                    64'(want.label));
                if (m_axis_tdata[lwh_pkg::BIN_LABEL_W +: lwh_pkg::SUM_W] !== want.sum)
                    report_mismatch("bin_sum",
                                    64'(m_axis_tdata[lwh_pkg::BIN_LABEL_W +: lwh_pkg::SUM_W]),
                                    64'(want.sum));
                if (m_axis_tuser[1] !== want.ovf)
                    report_mismatch("label_overflow_seen", 64'(m_axis_tuser[1]),
                                    64'(want.ovf));
            end
        end
    end

    // Feed items in bursts with random gaps
    always @(negedge i_clk) begin : feed
        t_voxel_item nxt;
        logic        drive_valid;
        drive_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            drive_valid = 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            drive_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                nxt          = pending_items.pop_front();
                s_axis_tuser <= nxt.kind;
                s_axis_tdata <= lwh_pkg::IN_DATA_W'({nxt.count, nxt.label});
                drive_valid  = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_axis_tvalid <= drive_valid;
    end

    // Accept results on a shifting stall pattern, with two long holds
    always @(negedge i_clk) begin : drain
        logic take;
        take = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = (next_hold_at < 300) ? 300 : 32'h7FFF_FFFF;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(1, 64);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  take = 1'b1;
                RX_HALF:  take = ($urandom_range(0, 1) == 0);
                default:  take = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_axis_tready <= take && i_rst_n;
    end

    // End the run if neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
